>>> rtl/ddu_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ddu_pkg
// Shared types, constants and helper functions for the date-time difference
// unit.
// ---------------------------------------------------------------------------
package ddu_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int DAYS_W  = 23;
    localparam int SECS_W  = 17;
    localparam int DNUM_W  = 24;
    localparam int TOD_W   = 17;
    localparam int TDIFF_W = TOD_W + 2;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int DAYS_PER_YEAR = 365;
    localparam int YEARS_PER_CYCLE = 400;

    typedef struct packed {
        logic [YEAR_W-1:0]  later_year;
        logic [MONTH_W-1:0] later_month;
        logic [DAY_W-1:0]   later_day;
        logic [HOUR_W-1:0]  later_hour;
        logic [MIN_W-1:0]   later_minute;
        logic [SEC_W-1:0]   later_second;
        logic [YEAR_W-1:0]  earlier_year;
        logic [MONTH_W-1:0] earlier_month;
        logic [DAY_W-1:0]   earlier_day;
        logic [HOUR_W-1:0]  earlier_hour;
        logic [MIN_W-1:0]   earlier_minute;
        logic [SEC_W-1:0]   earlier_second;
    } in_item_t;

    typedef struct packed {
        logic signed [DAYS_W-1:0] elapsed_days;
        logic [SECS_W-1:0]        elapsed_seconds;
        logic                     bad_date;
    } out_item_t;

    // floor(x / 25) for x < 4699, by reciprocal multiply
    function automatic logic [7:0] div25(input logic [12:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd1311;
        return p[22:15];
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_FEB: len = 5'd28;
            MONTH_APR: len = 5'd30;
            MONTH_JUN: len = 5'd30;
            MONTH_SEP: len = 5'd30;
            MONTH_NOV: len = 5'd30;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

    // Days from March 1 to the first of the month; year starts in March.
    // Month 0 counts as January, above 12 as December.
    function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [8:0] off;
        case (m)
            4'd0:      off = 9'd306;
            MONTH_JAN: off = 9'd306;
            MONTH_FEB: off = 9'd337;
            4'd3:      off = 9'd0;
            MONTH_APR: off = 9'd31;
            4'd5:      off = 9'd61;
            MONTH_JUN: off = 9'd92;
            4'd7:      off = 9'd122;
            4'd8:      off = 9'd153;
            MONTH_SEP: off = 9'd184;
            4'd10:     off = 9'd214;
            MONTH_NOV: off = 9'd245;
            default:   off = 9'd275;
        endcase
        return off;
    endfunction

    function automatic logic [TOD_W-1:0] tod_secs(input logic [HOUR_W-1:0] h,
                                                  input logic [MIN_W-1:0] mi,
                                                  input logic [SEC_W-1:0] s);
        return TOD_W'(h) * TOD_W'(SECS_PER_HOUR) + TOD_W'(mi) * TOD_W'(SECS_PER_MIN)
             + TOD_W'(s);
    endfunction

endpackage
`default_nettype wire

>>> rtl/ddu_in_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ddu_in_if
// Valid/ready channel carrying one pair of date-times per item.
// ---------------------------------------------------------------------------
interface ddu_in_if import ddu_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t item;

    modport source(output valid, output item, input ready);
    modport sink(input valid, input item, output ready);
endinterface
`default_nettype wire

>>> rtl/ddu_out_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ddu_out_if
// Valid/ready channel carrying one elapsed-time result per item.
// ---------------------------------------------------------------------------
interface ddu_out_if import ddu_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t item;

    modport source(output valid, output item, input ready);
    modport sink(input valid, input item, output ready);
endinterface
`default_nettype wire

>>> rtl/ddu_day_number.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ddu_day_number
// Gregorian date to linear day number, year offset by one 400-year cycle.
// ---------------------------------------------------------------------------
module ddu_day_number import ddu_pkg::*;
(
    input  logic [YEAR_W-1:0]  year,
    input  logic [MONTH_W-1:0] month,
    input  logic [DAY_W-1:0]   day,
    output logic [DNUM_W-1:0]  day_num
);

    logic        early;
    logic [14:0] yy;
    logic [12:0] q4;
    logic [10:0] q16;
    logic [7:0]  c100;
    logic [7:0]  c400;

    always_comb
    begin
        early = (month <= MONTH_FEB);
        yy    = 15'(year) + 15'(YEARS_PER_CYCLE) - 15'(early);
        q4    = yy[14:2];
        q16   = yy[14:4];
        c100  = div25(q4);
        c400  = div25(13'(q16));
        day_num = DNUM_W'(yy) * DNUM_W'(DAYS_PER_YEAR) + DNUM_W'(q4) - DNUM_W'(c100)
                + DNUM_W'(c400) + DNUM_W'(month_offset(month)) + DNUM_W'(day)
                - DNUM_W'(1);
    end

endmodule
`default_nettype wire

>>> rtl/ddu_date_check.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ddu_date_check
// Flags a month outside 1..12, a day of 0 or a day past the month's end.
// ---------------------------------------------------------------------------
module ddu_date_check import ddu_pkg::*;
(
    input  logic [YEAR_W-1:0]  year,
    input  logic [MONTH_W-1:0] month,
    input  logic [DAY_W-1:0]   day,
    output logic               bad
);

    logic [11:0]      q4;
    logic [9:0]       q16;
    logic [7:0]       c4;
    logic [7:0]       c16;
    logic             century;
    logic             quad_century;
    logic             leap;
    logic [DAY_W-1:0] len;

    always_comb
    begin
        q4  = year[13:2];
        q16 = year[13:4];
        c4  = div25(13'(q4));
        c16 = div25(13'(q16));
        century      = (13'(q4) == 13'(c4) * 13'd25);
        quad_century = (year[3:0] == 4'd0) && (13'(q16) == 13'(c16) * 13'd25);
        leap = (year[1:0] == 2'd0) && (!century || quad_century);
        len  = month_len(month) + DAY_W'((month == MONTH_FEB) && leap);
        bad  = (month < MONTH_JAN) || (month > MONTH_DEC) || (day == '0) || (day > len);
    end

endmodule
`default_nettype wire

>>> rtl/datetime_difference_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// datetime_difference_unit
// Elapsed days and seconds between two Gregorian date-times.
// ---------------------------------------------------------------------------
// Accepts one item per cycle while the output is not stalled: the item is
// captured in an input register, both dates are converted to day numbers
// and the time-of-day difference is folded into days and seconds, and the
// result lands in an output register. The longest path is the day-number
// conversion (constant multiply by the days per year plus the century
// corrections) feeding the day subtraction. A stalled output holds the
// output register and a full input register; the input takes a new item
// whenever either register is empty or the output drains in the same cycle.
module datetime_difference_unit import ddu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ddu_in_if.sink       dates,
    ddu_out_if.source    elapsed
);

    localparam logic signed [TDIFF_W-1:0] DAY_S  = TDIFF_W'(SECS_PER_DAY);
    localparam logic signed [TDIFF_W-1:0] DAY2_S = TDIFF_W'(2 * SECS_PER_DAY);

    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t out_reg;
    logic      out_valid_reg;
    logic      advance;
    logic      take;

    logic [DNUM_W-1:0]         dn_later;
    logic [DNUM_W-1:0]         dn_earlier;
    logic                      bad_later;
    logic                      bad_earlier;
    logic [TOD_W-1:0]          tod_later;
    logic [TOD_W-1:0]          tod_earlier;
    logic signed [TDIFF_W-1:0] tod_diff;
    logic signed [TDIFF_W-1:0] rem;
    logic signed [DNUM_W-1:0]  day_diff;
    logic signed [DNUM_W-1:0]  day_adj;
    out_item_t                 out_next;

    assign advance       = !out_valid_reg || elapsed.ready;
    assign dates.ready   = !in_valid_reg || advance;
    assign take          = dates.valid && dates.ready;
    assign elapsed.valid = out_valid_reg;
    assign elapsed.item  = out_reg;

    ddu_day_number u_dn_later
    (
        .year    (in_reg.later_year),
        .month   (in_reg.later_month),
        .day     (in_reg.later_day),
        .day_num (dn_later)
    );

    ddu_day_number u_dn_earlier
    (
        .year    (in_reg.earlier_year),
        .month   (in_reg.earlier_month),
        .day     (in_reg.earlier_day),
        .day_num (dn_earlier)
    );

    ddu_date_check u_chk_later
    (
        .year  (in_reg.later_year),
        .month (in_reg.later_month),
        .day   (in_reg.later_day),
        .bad   (bad_later)
    );

    ddu_date_check u_chk_earlier
    (
        .year  (in_reg.earlier_year),
        .month (in_reg.earlier_month),
        .day   (in_reg.earlier_day),
        .bad   (bad_earlier)
    );

    always_comb
    begin
        tod_later   = tod_secs(in_reg.later_hour, in_reg.later_minute, in_reg.later_second);
        tod_earlier = tod_secs(in_reg.earlier_hour, in_reg.earlier_minute,
                               in_reg.earlier_second);
        tod_diff = $signed(TDIFF_W'(tod_later)) - $signed(TDIFF_W'(tod_earlier));
        day_diff = $signed(dn_later) - $signed(dn_earlier);
        // fold time-of-day difference into whole days, floor division
        if (tod_diff < -DAY_S)
        begin
            day_adj = -DNUM_W'(2);
            rem     = tod_diff + DAY2_S;
        end
        else if (tod_diff < 0)
        begin
            day_adj = -DNUM_W'(1);
            rem     = tod_diff + DAY_S;
        end
        else if (tod_diff < DAY_S)
        begin
            day_adj = '0;
            rem     = tod_diff;
        end
        else
        begin
            day_adj = DNUM_W'(1);
            rem     = tod_diff - DAY_S;
        end
        out_next.elapsed_days    = DAYS_W'(day_diff + day_adj);
        out_next.elapsed_seconds = rem[SECS_W-1:0];
        out_next.bad_date        = bad_later || bad_earlier;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg <= dates.item;
        end
        if (advance && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    a_secs_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.elapsed_seconds < SECS_W'(SECS_PER_DAY)))
        else $error("elapsed seconds out of range");

    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> out_valid_reg)
        else $error("registered item did not reach the output");

    a_take_holds: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> in_valid_reg)
        else $error("accepted item not captured");

    a_bad_month: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance && (in_reg.later_month == '0)) |=> out_reg.bad_date)
        else $error("month zero not flagged");

endmodule
`default_nettype wire
